// ===== rtl/bums_pkg.sv =====
// ---------------------------------------------------------------------------
// bums_pkg
// Shared types and constants for the bottom-up merge sorter.
// ---------------------------------------------------------------------------
`default_nettype none

package bums_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Which head the merge unit consumes this cycle
  typedef struct packed {
    logic take_left;
    logic take_right;
  } sel_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_MERGE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bottom_up_merge_sorter.sv =====
// ---------------------------------------------------------------------------
// bottom_up_merge_sorter
// Collects a set of signed words, sorts them by bottom-up merge, emits them.
// ---------------------------------------------------------------------------
// Beats are loaded one per cycle into the primary buffer until a beat with
// in_last set; beats beyond MAX_ITEMS are dropped and flagged on out_overflow.
// The block then stops taking input and runs ceil(log2 n) merge passes that
// ping-pong between two buffers, one element per cycle through a single
// compare/select unit, with a setup and a close step for each run pair.
// Results then leave one per cycle while out_ready is high.
`default_nettype none

module bottom_up_merge_sorter
  import bums_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire data_t in_value,
  input  wire logic  in_last,
  output logic       out_valid,
  input  wire logic  out_ready,
  output data_t      out_value_res,
  output logic       out_last_res,
  output logic       out_overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 3;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ovf_r, ovf_nxt;
  logic [SW-1:0]   w_r, w_nxt;
  logic [CW-1:0]   start_r, start_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   end_r, end_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            src_r, src_nxt;
  logic            out_valid_r, out_valid_nxt;
  data_t           out_value_r, out_value_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            we_p, we_s;
  logic [AW-1:0]   waddr;
  data_t           wdata;
  data_t           p_rd_a, p_rd_b, s_rd_a, s_rd_b;
  data_t           head_left, head_right, sel_value;
  sel_t            sel;
  logic            left_ok, right_ok;
  logic [SW-1:0]   s_mid, s_end;

  bums_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_primary (
    .clk     (clk),
    .we      (we_p),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (i_nxt[AW-1:0]),
    .raddr_b (j_nxt[AW-1:0]),
    .rdata_a (p_rd_a),
    .rdata_b (p_rd_b)
  );

  bums_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_scratch (
    .clk     (clk),
    .we      (we_s),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (i_nxt[AW-1:0]),
    .raddr_b (j_nxt[AW-1:0]),
    .rdata_a (s_rd_a),
    .rdata_b (s_rd_b)
  );

  // read data always belongs to the addresses i_r / j_r
  assign head_left  = src_r ? s_rd_a : p_rd_a;
  assign head_right = src_r ? s_rd_b : p_rd_b;
  assign left_ok    = (i_r < mid_r);
  assign right_ok   = (j_r < end_r);

  bums_merge_unit u_merge (
    .head_left  (head_left),
    .head_right (head_right),
    .left_ok    (left_ok),
    .right_ok   (right_ok),
    .sel        (sel),
    .sel_value  (sel_value)
  );

  assign s_mid = SW'(start_r) + w_r;
  assign s_end = SW'(start_r) + (w_r << 1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    w_nxt         = w_r;
    start_nxt     = start_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    end_nxt       = end_r;
    k_nxt         = k_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    in_ready      = 1'b0;
    we_p          = 1'b0;
    we_s          = 1'b0;
    waddr         = k_r[AW-1:0];
    wdata         = sel_value;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < MAX_CNT) begin
            we_p      = 1'b1;
            waddr     = count_r[AW-1:0];
            wdata     = in_value;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_SETUP;
            w_nxt     = SW'(1);
            start_nxt = '0;
            src_nxt   = 1'b0;
          end
        end
      end
      S_SETUP: begin
        if (w_r >= SW'(count_r)) begin
          state_nxt = S_EMIT;
          i_nxt     = '0;
        end else begin
          state_nxt = S_MERGE;
          i_nxt     = start_r;
          k_nxt     = start_r;
          mid_nxt   = (s_mid > SW'(count_r)) ? count_r : s_mid[CW-1:0];
          end_nxt   = (s_end > SW'(count_r)) ? count_r : s_end[CW-1:0];
          j_nxt     = mid_nxt;
        end
      end
      S_MERGE: begin
        if (sel.take_left || sel.take_right) begin
          we_p  = src_r;
          we_s  = !src_r;
          k_nxt = k_r + CW'(1);
          if (sel.take_left) begin
            i_nxt = i_r + CW'(1);
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end else begin
          state_nxt = S_SETUP;
          start_nxt = end_r;
          if (end_r == count_r) begin
            // pass complete: double the run width, swap buffers
            w_nxt     = w_r << 1;
            src_nxt   = !src_r;
            start_nxt = '0;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = head_left;
          out_last_nxt  = (i_r + CW'(1) == count_r);
          out_ovf_nxt   = ovf_r;
          i_nxt         = i_r + CW'(1);
          if (i_r + CW'(1) == count_r) begin
            state_nxt = S_IDLE;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      src_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      src_r       <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    start_r     <= start_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    mid_r       <= mid_nxt;
    end_r       <= end_nxt;
    k_r         <= k_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;
  assign out_overflow  = out_ovf_r;

  // only one buffer is ever written in a cycle
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_p && we_s))
    else $error("both buffers written in one cycle");

  // write pointer tracks the elements consumed from both runs
  a_k_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (k_r == CW'(i_r + (j_r - mid_r))))
    else $error("merge write index out of step");

  // the merge unit never takes both heads while merging
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> $onehot0({sel.take_left, sel.take_right}))
    else $error("merge unit took both heads");

  // a new result beat only comes out of the emit phase
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result beat outside emit phase");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("element count beyond capacity");

endmodule

`default_nettype wire

// ===== rtl/bums_ram.sv =====
// ---------------------------------------------------------------------------
// bums_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bums_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/bums_merge_unit.sv =====
// ---------------------------------------------------------------------------
// bums_merge_unit
// Shared compare/select step: picks the next element of a run pair.
// ---------------------------------------------------------------------------
`default_nettype none

module bums_merge_unit
  import bums_pkg::*;
(
  input  wire data_t head_left,
  input  wire data_t head_right,
  input  wire logic  left_ok,
  input  wire logic  right_ok,
  output sel_t       sel,
  output data_t      sel_value
);

  // ties go to the right run
  always_comb begin
    sel.take_left  = left_ok && (!right_ok || (head_left < head_right));
    sel.take_right = right_ok && !sel.take_left;
    sel_value      = sel.take_left ? head_left : head_right;
  end

endmodule

`default_nettype wire

// ===== tb/sv/bottom_up_merge_sorter_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bottom_up_merge_sorter_tb
// Self-checking bench for the merge sorter: sends sets of signed words,
// predicts the sorted beats with the overflow flag, compares every result.
// ---------------------------------------------------------------------------
module bottom_up_merge_sorter_tb;
  import bums_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_BEATS  = 72;

  typedef struct {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_beat_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  data_t in_value;
  logic  in_last;
  logic  out_valid;
  logic  out_ready;
  data_t out_value_res;
  logic  out_last_res;
  logic  out_overflow;

  bottom_up_merge_sorter #(
    .MAX_ITEMS(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value_res(out_value_res),
    .out_last_res (out_last_res),
    .out_overflow (out_overflow)
  );

  // predictor state: the set being collected and the sorted beats still owed
  data_t        pending_set[$];
  logic         set_dropped;
  sorted_beat_t sorted_q[$];
  sorted_beat_t head_beat;

  int errors;
  int beats_sent;
  int results_seen;
  int sets_sorted;
  int overflow_sets;
  int idle_cycles;
  bit steady;
  bit hold_on;
  event begin_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sorts the collected set by insertion and queues one beat per element
  function automatic void collect_beat(input data_t v, input logic l);
    data_t ordered[$];
    int    pos;
    if (pending_set.size() < CAPACITY) pending_set.push_back(v);
    else set_dropped = 1'b1;
    if (!l) return;
    foreach (pending_set[i]) begin
      pos = 0;
      while (pos < ordered.size() && ordered[pos] <= pending_set[i]) pos++;
      ordered.insert(pos, pending_set[i]);
    end
    foreach (ordered[i]) begin
      sorted_q.push_back('{value: ordered[i], last: (i == ordered.size() - 1),
                           ovf: set_dropped});
    end
    sets_sorted++;
    if (set_dropped) overflow_sets++;
    pending_set.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic data_t pick_value(input int mode);
    case (mode)
      0: pick_value = $urandom_range(0, 8) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: pick_value = 32'sh7fff_ffff;
          1: pick_value = 32'sh8000_0000;
          2: pick_value = 0;
          3: pick_value = -1;
          4: pick_value = 1;
          default: pick_value = $urandom;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // called just after a rising edge; returns at the edge that takes the beat
  task automatic send_beat(input data_t v, input logic l);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= l;
    do @(posedge clk); while (in_ready !== 1'b1);
    beats_sent++;
    collect_beat(v, l);
  endtask

  task automatic send_set(input data_t vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int count, input int mode);
    data_t vals[$];
    repeat (count) vals.push_back(pick_value(mode));
    send_set(vals);
  endtask

  // sender goes quiet until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_set('{-1});
    send_set('{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1});
    send_set('{5, 5, -5, 5});
    send_set('{-3, 0, 7, 100});
    send_set('{9, 2, -2, 32'sh8000_0000});
    drain_results();
  endtask

  task automatic test_capacity();
    // exactly full with no idling on either side, then overflow where the
    // last beat itself is dropped
    steady = 1'b1;
    send_random_set(CAPACITY, 2);
    drain_results();
    steady = 1'b0;
    send_random_set(CAPACITY + 3, 2);
    drain_results();
    // flag must clear for the following set
    send_random_set(3, 1);
    drain_results();
  endtask

  task automatic test_backpressure();
    -> begin_hold;
    send_random_set(16, 2);
    send_random_set(10, 0);
    drain_results();
  endtask

  task automatic test_random();
    int target;
    int set_idx;
    int r;
    int count;
    target  = beats_sent + RANDOM_BEATS;
    set_idx = 0;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) count = $urandom_range(1, 12);
      else if (r < 92) count = $urandom_range(13, 40);
      else if (r < 97) count = $urandom_range(41, CAPACITY);
      else count = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      send_random_set(count, $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) drain_results();
      set_idx++;
    end
    drain_results();
  endtask

  // receiver side: random idling, or a long hold counted here
  initial begin
    hold_on = 1'b0;
    forever begin
      @(begin_hold);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_on) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat value=%0d last=%0b overflow=%0b", $time,
                 out_value_res, out_last_res, out_overflow);
      end else begin
        head_beat = sorted_q.pop_front();
        if (out_value_res !== head_beat.value) begin
          errors++;
          $display("%0t: value mismatch expected=%0d actual=%0d", $time,
                   head_beat.value, out_value_res);
        end
        if (out_last_res !== head_beat.last) begin
          errors++;
          $display("%0t: last mismatch expected=%0b actual=%0b", $time,
                   head_beat.last, out_last_res);
        end
        if (out_overflow !== head_beat.ovf) begin
          errors++;
          $display("%0t: overflow mismatch expected=%0b actual=%0b", $time,
                   head_beat.ovf, out_overflow);
        end
      end
    end
  end

  // watchdog: sorting a full set plus the long hold stays well inside this
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results owed", $time,
               STALL_LIMIT, sorted_q.size());
      $display("bottom_up_merge_sorter verification failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_last      = 1'b0;
    out_ready    = 1'b0;
    set_dropped  = 1'b0;
    errors       = 0;
    beats_sent   = 0;
    results_seen = 0;
    sets_sorted  = 0;
    overflow_sets = 0;
    idle_cycles  = 0;
    steady       = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_backpressure();
    test_random();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d input beats in %0d sets (%0d with dropped beats),", beats_sent,
             sets_sorted, overflow_sets);
    $display("%0d sorted beats checked, long output hold and input stall included.",
             results_seen);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("bottom_up_merge_sorter verification clean");
    end else begin
      $display("bottom_up_merge_sorter verification failed");
    end
    $finish;
  end

endmodule

// ===== bottom_up_merge_sorter.f =====
rtl/bums_pkg.sv
rtl/bums_ram.sv
rtl/bums_merge_unit.sv
rtl/bottom_up_merge_sorter.sv
tb/sv/bottom_up_merge_sorter_tb.sv
